FILE: sv/cat_pkg.sv
package cat_pkg;

  // Default sizes of the table.
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int NAME_BYTES_DEF  = 16;

  // Name bytes carried by the input word and kept in a record.
  localparam int NAME_CARRIED = 14;
  localparam int NAME_W       = 8 * NAME_CARRIED;

  // Operation codes.
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_DEL = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_LONG  = 3'd2;
  localparam logic [2:0] ST_SHORT = 3'd3;
  localparam logic [2:0] ST_NOID  = 3'd4;

  // The built-in account that sits in entry 0 after reset.
  localparam logic [31:0]     SYSTEM_ID   = 32'hFFFF_FFFF;
  localparam logic [NAME_W-1:0] SYSTEM_NAME = NAME_W'(48'h6D6574737973);

  typedef struct packed {
    logic [31:0]       id;
    logic [31:0]       hash;
    logic [NAME_W-1:0] name;
    logic              sys;
  } record_t;

  localparam record_t SYSTEM_REC = '{
    id:   SYSTEM_ID,
    hash: 32'h0,
    name: SYSTEM_NAME,
    sys:  1'b1
  };

  // Per-cell controls driven by the sequencer.
  typedef struct packed {
    logic write;  // load the new record
    logic shift;  // take the record of the next cell up
    logic cmp;    // capture the id comparison
    logic live;   // the cell holds a live entry
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

FILE: sv/cat_cell.sv
module cat_cell #(
  parameter bit HEAD = 1'b0
) (
  input  logic               clk,
  input  logic               rst,
  input  cat_pkg::cell_ctl_t ctl,
  input  logic [31:0]        uid,
  input  cat_pkg::record_t   new_rec,
  input  cat_pkg::record_t   nbr_rec,
  output cat_pkg::record_t   rec,
  output logic               match
);
  import cat_pkg::*;

  // One table entry. A write wins over a shift; the two never coincide.
  always_ff @(posedge clk) begin
    if (rst) begin
      rec   <= HEAD ? SYSTEM_REC : record_t'('0);
      match <= 1'b0;
    end else begin
      if (ctl.write) begin
        rec <= new_rec;
      end else if (ctl.shift) begin
        rec <= nbr_rec;
      end
      if (ctl.cmp) begin
        match <= ctl.live && (rec.id == uid);
      end
    end
  end

endmodule

FILE: sv/cat_scan.sv
module cat_scan #(
  parameter int DEPTH = cat_pkg::TABLE_DEPTH_DEF
) (
  input  logic [DEPTH-1:0] match,
  output logic [DEPTH-1:0] upto,
  output logic [DEPTH-1:0] first,
  output logic             found
);
  localparam int LV = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Parallel prefix OR: upto[i] is set when any cell at or below i matched.
  logic [DEPTH-1:0] lvl [LV+1];

  assign lvl[0] = match;

  for (genvar l = 0; l < LV; l++) begin : g_lvl
    always_comb begin
      lvl[l+1] = lvl[l] | (lvl[l] << (1 << l));
    end
  end

  assign upto  = lvl[LV];
  assign first = upto & ~(upto << 1);
  assign found = upto[DEPTH-1];

endmodule

FILE: sv/compacting_account_table_top.sv
// The sequencer holds one operation at a time: an add steps through the compare and done
// states, a delete also through the shift state, and the next word is taken once the result
// sits in the output register.
// Reset (rst, synchronous, active high) loads entry 0 with the system account, clears the
// other entries, sets the entry count to one and empties the output register.
module compacting_account_table_top #(
  parameter int TABLE_DEPTH = cat_pkg::TABLE_DEPTH_DEF,
  parameter int NAME_BYTES  = cat_pkg::NAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic signed [31:0] uid,
  input  logic [63:0]        name_lo,
  input  logic [47:0]        name_hi,
  input  logic [7:0]         name_len,
  input  logic signed [31:0] passwd_hash,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [7:0]         slot,
  output logic [8:0]         entry_count
);
  import cat_pkg::*;

  // The table is a row of cells, one per entry. Live entries always fill
  // cells 0 to count-1 in the order they were added; cells above stay zero.
  //
  // An add checks the count and the name length in the compare state
  // and, if accepted, writes the record straight into the cell at the tail.
  //
  // A delete uses the compare state, then the shift state. In the first, every
  // cell compares its id with the requested one at once and keeps the outcome.
  // In the second, a prefix OR over those outcomes marks the first matching
  // cell and every cell above it; each marked cell takes the record of its
  // upper neighbor, which closes the gap in one step. The top cell takes zero.
  //
  // The done state encodes the removed slot and places the result word in the
  // output register once free; it holds the word until the consumer takes it.

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_t state, state_next;

  logic [CW-1:0] count;

  // Captured request.
  logic          req_op;
  logic [31:0]   req_uid;
  logic [7:0]    req_len;
  record_t       req_rec;

  // Pending result.
  logic [2:0]             res_status;
  logic [7:0]             res_slot;
  logic                   res_del_ok;
  logic [TABLE_DEPTH-1:0] first_oh;

  // Control strobes from the sequencer.
  logic add_en;
  logic cmp_en;
  logic shift_en;
  logic out_load;

  logic [2:0]        add_status;
  logic [NAME_W-1:0] name_full;
  logic [NAME_W-1:0] name_keep;
  logic [IW-1:0]     del_idx;

  record_t                recs  [TABLE_DEPTH];
  cell_ctl_t              ctls  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match;
  logic [TABLE_DEPTH-1:0] upto;
  logic [TABLE_DEPTH-1:0] first;
  logic                   found;

  // Only the first name_len bytes of the name are kept.
  assign name_full = {name_hi, name_lo};

  always_comb begin
    name_keep = '0;
    for (int k = 0; k < NAME_CARRIED; k++) begin
      if (name_len > 8'(k)) begin
        name_keep[8*k +: 8] = name_full[8*k +: 8];
      end
    end
  end

  // Add checks, in order of precedence: full table, long name, short name.
  always_comb begin
    if (count >= CW'(TABLE_DEPTH)) begin
      add_status = ST_FULL;
    end else if (({1'b0, req_len} + 9'd1) >= 9'(NAME_BYTES)) begin
      add_status = ST_LONG;
    end else if (req_len <= 8'd1) begin
      add_status = ST_SHORT;
    end else begin
      add_status = ST_OK;
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = (req_op == OP_DEL) ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_stall = 1'b1;
    add_en   = 1'b0;
    cmp_en   = 1'b0;
    shift_en = 1'b0;
    out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_CMP: begin
        add_en = (req_op == OP_ADD) && (add_status == ST_OK);
        cmp_en = (req_op == OP_DEL);
      end
      S_SHIFT: begin
        shift_en = found;
      end
      S_DONE: begin
        out_load = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= CW'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (add_en) begin
        count <= count + CW'(1);
      end else if (shift_en) begin
        count <= count - CW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture and pending result.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_op       <= op;
      req_uid      <= uid;
      req_len      <= name_len;
      req_rec.id   <= uid;
      req_rec.hash <= passwd_hash;
      req_rec.name <= name_keep;
      req_rec.sys  <= 1'b0;
    end
    if (state == S_CMP) begin
      res_status <= add_status;
      res_slot   <= (add_status == ST_OK) ? 8'(count) : 8'd0;
      res_del_ok <= 1'b0;
    end
    if (state == S_SHIFT) begin
      res_status <= found ? ST_OK : ST_NOID;
      res_slot   <= 8'd0;
      res_del_ok <= found;
      first_oh   <= first;
    end
  end

  // Turn the marker of the removed cell into its index.
  always_comb begin
    del_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (first_oh[i]) begin
        del_idx = del_idx | IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      slot        <= res_del_ok ? 8'(del_idx) : res_slot;
      entry_count <= 9'(count);
    end
  end

  // The row of cells.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    always_comb begin
      ctls[i].write = add_en && (count == CW'(i));
      ctls[i].shift = shift_en && upto[i];
      ctls[i].cmp   = cmp_en;
      ctls[i].live  = CW'(i) < count;
    end

    if (i == TABLE_DEPTH - 1) begin : g_top
      cat_cell #(
        .HEAD (i == 0)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctls[i]),
        .uid     (req_uid),
        .new_rec (req_rec),
        .nbr_rec (record_t'('0)),
        .rec     (recs[i]),
        .match   (match[i])
      );
    end else begin : g_mid
      cat_cell #(
        .HEAD (i == 0)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctls[i]),
        .uid     (req_uid),
        .new_rec (req_rec),
        .nbr_rec (recs[i+1]),
        .rec     (recs[i]),
        .match   (match[i])
      );
    end
  end

  cat_scan #(
    .DEPTH (TABLE_DEPTH)
  ) u_scan (
    .match (match),
    .upto  (upto),
    .first (first),
    .found (found)
  );

  // The entry count never exceeds the table depth.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // The count only moves while an operation is being worked on.
  assert property (@(posedge clk) disable iff (rst) state == S_IDLE |=> count == $past(count))
    else $error("entry count changed while idle");

  // A new result word only comes from the final sequencer step.
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result word without a finished operation");

  // A delete removes at most one entry.
  assert property (@(posedge clk) disable iff (rst) state == S_DONE |-> $onehot0(first_oh))
    else $error("more than one cell marked for removal");

  // A shift step always lowers the count by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    shift_en |=> count == $past(count) - CW'(1))
    else $error("delete did not lower the count");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cat_pkg::*;

  // The block is built with its default sizes; the local table mirrors them.
  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int NAME_BYTES  = NAME_BYTES_DEF;

  // One request word as it crosses the input channel.
  typedef struct {
    logic        op;
    logic [31:0] uid;
    logic [63:0] name_lo;
    logic [47:0] name_hi;
    logic [7:0]  name_len;
    logic [31:0] hash;
  } acct_word_t;

  // One result word as it leaves the output channel.
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] slot;
    logic [8:0] count;
  } acct_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               op;
  logic signed [31:0] uid;
  logic [63:0]        name_lo;
  logic [47:0]        name_hi;
  logic [7:0]         name_len;
  logic signed [31:0] passwd_hash;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         status;
  logic [7:0]         slot;
  logic [8:0]         entry_count;

  // Our own copy of the account table. Live entries sit in 0 .. live_n-1.
  logic [31:0]       acct_ids    [TABLE_DEPTH];
  logic [31:0]       acct_hashes [TABLE_DEPTH];
  logic [NAME_W-1:0] acct_names  [TABLE_DEPTH];
  logic              acct_sys    [TABLE_DEPTH];
  int                live_n;

  // Results that accepted words have caused and that have not come out yet.
  acct_result_t pending_results[$];

  int fail_count = 0;
  int ret_hold   = 0;
  bit quiet      = 1'b0;

  compacting_account_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NAME_BYTES (NAME_BYTES)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .uid        (uid),
    .name_lo    (name_lo),
    .name_hi    (name_hi),
    .name_len   (name_len),
    .passwd_hash(passwd_hash),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .slot       (slot),
    .entry_count(entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both sides idle for a random gap per word, except during quiet stretches
  // where they run flat out. The quiet flag flips at random intervals.
  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  initial begin
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      quiet <= ~quiet;
    end
  end

  // ---------------------------------------------------------------------------
  // Table predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_entry(int i);
    acct_ids[i]    = '0;
    acct_hashes[i] = '0;
    acct_names[i]  = '0;
    acct_sys[i]    = 1'b0;
  endfunction

  // After reset only the system account is present, in entry 0.
  function automatic void reset_table();
    for (int i = 0; i < TABLE_DEPTH; i++) clear_entry(i);
    acct_ids[0]   = SYSTEM_ID;
    acct_names[0] = SYSTEM_NAME;
    acct_sys[0]   = 1'b1;
    live_n        = 1;
  endfunction

  // Applies one accepted word to the table and returns the result it causes.
  function automatic acct_result_t apply_word(acct_word_t w);
    acct_result_t      res;
    logic [NAME_W-1:0] kept;
    int                hit;
    res.status = ST_OK;
    res.slot   = '0;
    if (w.op == OP_ADD) begin
      // The refusal checks are ordered: full, then too long, then too short.
      if (live_n >= TABLE_DEPTH) begin
        res.status = ST_FULL;
      end else if (int'(w.name_len) + 1 >= NAME_BYTES) begin
        res.status = ST_LONG;
      end else if (w.name_len <= 8'd1) begin
        res.status = ST_SHORT;
      end else begin
        // Only the first name_len bytes of the name are kept, the rest is zero.
        kept = {w.name_hi, w.name_lo};
        if (int'(w.name_len) < NAME_CARRIED)
          kept &= ~({NAME_W{1'b1}} << (8 * int'(w.name_len)));
        res.slot            = 8'(live_n);
        acct_ids[live_n]    = w.uid;
        acct_hashes[live_n] = w.hash;
        acct_names[live_n]  = kept;
        acct_sys[live_n]    = 1'b0;
        live_n++;
      end
    end else begin
      // Only live entries are searched, and the first match wins.
      hit = -1;
      for (int i = 0; i < live_n; i++)
        if (hit < 0 && acct_ids[i] == w.uid) hit = i;
      if (hit < 0) begin
        res.status = ST_NOID;
      end else begin
        res.slot = 8'(hit);
        for (int j = hit; j + 1 < live_n; j++) begin
          acct_ids[j]    = acct_ids[j + 1];
          acct_hashes[j] = acct_hashes[j + 1];
          acct_names[j]  = acct_names[j + 1];
          acct_sys[j]    = acct_sys[j + 1];
        end
        live_n--;
        clear_entry(live_n);
      end
    end
    res.count = 9'(live_n);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------------

  // Half of the ids come from a small pool so that duplicates are common.
  function automatic logic [31:0] pick_uid();
    return $urandom_range(0, 1) ? 32'($urandom_range(0, 31)) : 32'($urandom);
  endfunction

  // A length that an add refuses: too short or too long.
  function automatic logic [7:0] bad_len();
    return $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(15, 255));
  endfunction

  function automatic logic [31:0] live_uid();
    return acct_ids[$urandom_range(0, live_n - 1)];
  endfunction

  function automatic acct_word_t add_word(logic [31:0] id, logic [7:0] len);
    acct_word_t w;
    w.op       = OP_ADD;
    w.uid      = id;
    w.name_lo  = {$urandom, $urandom};
    w.name_hi  = 48'({$urandom, $urandom});
    w.name_len = len;
    w.hash     = $urandom;
    return w;
  endfunction

  // A delete carries random name and password fields, which it must ignore.
  function automatic acct_word_t del_word(logic [31:0] id);
    acct_word_t w;
    w    = add_word(id, 8'($urandom));
    w.op = OP_DEL;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Presents one word after a random gap and waits until it is taken. Valid is
  // left high after acceptance so that back-to-back words need no toggle; the
  // next call lowers it only when it decides to leave a gap.
  task automatic send_word(acct_word_t w);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= w.op;
    uid         <= w.uid;
    name_lo     <= w.name_lo;
    name_hi     <= w.name_hi;
    name_len    <= w.name_len;
    passwd_hash <= w.hash;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_word(w));
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Each accepted result word is compared with the oldest prediction. After
  // each result the receiver stalls for a freshly drawn number of cycles.
  always @(posedge clk) begin
    acct_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d slot %0d entry_count %0d",
                               status, slot, entry_count));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || slot !== want.slot || entry_count !== want.count)
          note_failure($sformatf({"mismatch: status %0d (exp %0d), slot %0d (exp %0d), ",
                                  "entry_count %0d (exp %0d)"},
                                 status, want.status, slot, want.slot,
                                 entry_count, want.count));
      end
      ret_hold = draw_wait();
    end else if (ret_hold > 0) begin
      ret_hold--;
    end
    out_stall <= (ret_hold > 0);
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Boundary lengths, extreme ids and hashes, a duplicate of the system id,
  // deleting the system account, emptying the table and a delete on an empty
  // table whose cleared slots hold id 0.
  task automatic test_directed();
    acct_word_t w;
    send_word(del_word(32'd5));
    send_word(add_word(32'd7, 8'd0));
    send_word(add_word(32'd7, 8'd1));
    send_word(add_word(32'd7, 8'd15));
    send_word(add_word(32'd7, 8'd255));
    w = add_word(32'h7FFF_FFFF, 8'd14);
    w.name_lo = '1;
    w.name_hi = '1;
    w.hash    = 32'h8000_0000;
    send_word(w);
    w = add_word(32'h8000_0000, 8'd2);
    w.name_lo = '0;
    w.name_hi = '0;
    w.hash    = 32'h7FFF_FFFF;
    send_word(w);
    send_word(add_word(SYSTEM_ID, 8'd8));
    send_word(add_word(32'd0, 8'd9));
    // The first delete of the system id hits entry 0, the second one the copy.
    send_word(del_word(SYSTEM_ID));
    send_word(del_word(SYSTEM_ID));
    send_word(del_word(32'd0));
    send_word(del_word(32'h7FFF_FFFF));
    send_word(del_word(32'h8000_0000));
    send_word(del_word(32'd0));
    send_word(add_word(32'd0, 8'd3));
    send_word(add_word(32'd0, 8'd13));
    send_word(del_word(32'd0));
  endtask

  // Fills the table to the last slot, then checks that a full table is
  // reported ahead of the name checks, and frees and refills one entry.
  task automatic test_fill();
    while (live_n < TABLE_DEPTH) begin
      if ($urandom_range(0, 9) == 0)
        send_word(add_word(pick_uid(), bad_len()));
      else
        send_word(add_word(pick_uid(), 8'($urandom_range(2, 14))));
    end
    send_word(add_word(pick_uid(), 8'd15));
    send_word(add_word(pick_uid(), 8'd0));
    send_word(add_word(pick_uid(), 8'd6));
    send_word(del_word(acct_ids[TABLE_DEPTH - 1]));
    send_word(add_word(pick_uid(), 8'd14));
    send_word(add_word(pick_uid(), 8'd2));
  endtask

  // Mostly deletes of ids that are present, at random positions, so the
  // compaction is exercised from random depths, until the table is empty, then three more deletes.
  task automatic test_drain();
    while (live_n > 0) begin
      if ($urandom_range(0, 6) == 0)
        send_word(del_word(pick_uid()));
      else
        send_word(del_word(live_uid()));
    end
    repeat (3) send_word(del_word(pick_uid()));
  endtask

  // A random mix that drifts slowly upward: valid adds, adds with any length,
  // deletes of present ids and deletes of arbitrary ids.
  task automatic test_random();
    int pick;
    repeat (800) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        send_word(add_word(pick_uid(), 8'($urandom_range(2, 14))));
      else if (pick < 55)
        send_word(add_word(pick_uid(), 8'($urandom)));
      else if (pick < 90 && live_n > 0)
        send_word(del_word(live_uid()));
      else
        send_word(del_word(pick_uid()));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    op          <= OP_ADD;
    uid         <= '0;
    name_lo     <= '0;
    name_hi     <= '0;
    name_len    <= '0;
    passwd_hash <= '0;
    reset_table();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill();
    test_drain();
    test_random();
    in_valid <= 1'b0;

    // Drain the outstanding results, then keep the clock running so that any
    // stray result word would show.
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // The slowest legal run is well under a millisecond; this is a hang guard.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
sv/cat_pkg.sv
sv/cat_cell.sv
sv/cat_scan.sv
sv/compacting_account_table_top.sv
sim/tb_top.sv
